### src/mmsq_pkg.sv
// Shared types, constants and the 16-case segment table for the
// multi-label marching squares cell. No dependencies.
package mmsq_pkg;

  localparam int LABEL_BITS_DEF = 8;
  localparam int COORD_BITS_DEF = 32;

  localparam int CORNERS    = 4;
  localparam int MAX_SEGS   = 4;
  localparam int LBL_W      = 8;
  localparam int PLANE_W    = 16;
  localparam int POS_W      = 33;
  localparam int HALF_W     = 20;
  localparam int MASK_W     = 4;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_RAW_W  = LBL_W + PLANE_W + 4 * POS_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LABEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_CELL_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_CELL_Y   = 2'd2;

  // offsets in units of the half cell
  localparam logic [1:0] D_Z = 2'b00;
  localparam logic [1:0] D_P = 2'b01;
  localparam logic [1:0] D_N = 2'b11;

  typedef struct packed {
    logic [1:0] sx;
    logic [1:0] sy;
    logic [1:0] ex;
    logic [1:0] ey;
  } delta_t;

  // decoded square: up to four segments, already compacted
  typedef struct packed {
    logic [CNT_W-1:0]               n;
    logic [MAX_SEGS-1:0][LBL_W-1:0] label;
    logic [MAX_SEGS-1:0][3:0]       idx;
    logic [MAX_SEGS-1:0]            sel;
    logic [PLANE_W-1:0]             plane;
    logic [POS_W-1:0]               cx;
    logic [POS_W-1:0]               cy;
  } square_t;

  function automatic logic [1:0] seg_count(input logic [3:0] idx);
    logic [1:0] c;
    unique case (idx)
      4'd0, 4'd15: c = 2'd0;
      4'd6, 4'd9:  c = 2'd2;
      default:     c = 2'd1;
    endcase
    return c;
  endfunction

  function automatic delta_t seg_delta(input logic [3:0] idx, input logic sel);
    delta_t d;
    unique case (idx)
      4'd1:    d = '{D_Z, D_P, D_P, D_Z};
      4'd2:    d = '{D_N, D_Z, D_Z, D_P};
      4'd3:    d = '{D_N, D_Z, D_P, D_Z};
      4'd4:    d = '{D_P, D_Z, D_Z, D_N};
      4'd5:    d = '{D_Z, D_P, D_Z, D_N};
      4'd6:    d = sel ? delta_t'{D_P, D_Z, D_Z, D_N} : delta_t'{D_N, D_Z, D_Z, D_P};
      4'd7:    d = '{D_N, D_Z, D_Z, D_N};
      4'd8:    d = '{D_Z, D_N, D_N, D_Z};
      4'd9:    d = sel ? delta_t'{D_Z, D_P, D_P, D_Z} : delta_t'{D_Z, D_N, D_N, D_Z};
      4'd10:   d = '{D_Z, D_N, D_Z, D_P};
      4'd11:   d = '{D_Z, D_N, D_P, D_Z};
      4'd12:   d = '{D_P, D_Z, D_N, D_Z};
      4'd13:   d = '{D_Z, D_P, D_N, D_Z};
      4'd14:   d = '{D_P, D_Z, D_Z, D_P};
      default: d = '{D_Z, D_Z, D_Z, D_Z};
    endcase
    return d;
  endfunction

  function automatic logic [POS_W-1:0] offset_by(input logic [POS_W-1:0] c,
                                                  input logic [1:0] d,
                                                  input logic [HALF_W-1:0] h);
    logic [POS_W-1:0] r;
    unique case (d)
      D_P:     r = c + POS_W'(h);
      D_N:     r = c - POS_W'(h);
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

### src/multilabel_marching_squares_cell.sv
// Multi-label marching squares cell: one square in, 0 to 4 segment beats out.
// The first segment passes the input, work and output registers to reach m_tdata.
// Throughput: one segment per cycle while m_tready allows; a pointer walks the
// decoded segment slots of the work register into the single output register.
// rst (sync, high) empties all stages and clears the three config registers.
// Depends on mmsq_pkg and mmsq_decode.
module multilabel_marching_squares_cell
  import mmsq_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_RAW_W  = CORNERS * LABEL_BITS + MASK_W + 2 * COORD_BITS + PLANE_W,
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // label_far_far, label_near_far, label_far_near, label_near_near,
  // present_mask, origin_x, origin_y, plane_index
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // seg_label, seg_plane, start_x, start_y, end_x, end_y
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MASK_LO = CORNERS * LABEL_BITS;
  localparam int OX_LO   = MASK_LO + MASK_W;
  localparam int OY_LO   = OX_LO + COORD_BITS;
  localparam int PL_LO   = OY_LO + COORD_BITS;

  logic [LABEL_BITS-1:0] default_label;
  logic [HALF_W-1:0]     half_cell_x;
  logic [HALF_W-1:0]     half_cell_y;

  logic            in_valid;
  logic [IN_W-1:0] in_data;
  square_t         dec;
  logic            work_valid;
  square_t         work;
  logic [1:0]      ptr;

  logic   out_load, last_slot, work_done, work_free, in_adv, work_load;
  delta_t d;

  assign cfg_ready = 1'b1;

  mmsq_decode #(
    .LABEL_BITS(LABEL_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .labels        (in_data[MASK_LO-1:0]),
    .present       (in_data[OX_LO-1:MASK_LO]),
    .origin_x      (in_data[OY_LO-1:OX_LO]),
    .origin_y      (in_data[PL_LO-1:OY_LO]),
    .plane         (in_data[PL_LO+PLANE_W-1:PL_LO]),
    .default_label (default_label),
    .half_cell_x   (half_cell_x),
    .half_cell_y   (half_cell_y),
    .sq            (dec)
  );

  assign out_load  = work_valid && (!m_tvalid || m_tready);
  assign last_slot = {1'b0, ptr} == work.n - CNT_W'(1);
  assign work_done = out_load && last_slot;
  assign work_free = !work_valid || work_done;
  assign in_adv    = in_valid && (dec.n == '0 || work_free);
  assign work_load = in_adv && dec.n != '0;
  assign s_tready  = !in_valid || in_adv;
  assign d         = seg_delta(work.idx[ptr], work.sel[ptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      work_valid    <= 1'b0;
      ptr           <= '0;
      m_tvalid      <= 1'b0;
      default_label <= '0;
      half_cell_x   <= '0;
      half_cell_y   <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (in_adv) begin
        in_valid <= 1'b0;
      end
      if (work_load) begin
        work_valid <= 1'b1;
        ptr        <= '0;
      end else if (work_done) begin
        work_valid <= 1'b0;
      end else if (out_load) begin
        ptr <= ptr + 2'd1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEFAULT_LABEL: default_label <= cfg_data[LABEL_BITS-1:0];
          CFG_HALF_CELL_X:   half_cell_x   <= cfg_data[HALF_W-1:0];
          CFG_HALF_CELL_Y:   half_cell_y   <= cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
    if (work_load) begin
      work <= dec;
    end
    if (out_load) begin
      m_tdata <= OUT_W'({offset_by(work.cy, d.ey, half_cell_y),
                         offset_by(work.cx, d.ex, half_cell_x),
                         offset_by(work.cy, d.sy, half_cell_y),
                         offset_by(work.cx, d.sx, half_cell_x),
                         work.plane,
                         work.label[ptr]});
      m_tlast <= last_slot;
    end
  end

  a_work_nonempty: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> work.n != '0)
    else $error("decoded square with no segments held");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> {1'b0, ptr} < work.n)
    else $error("segment pointer past segment count");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("square ended without a last beat");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tlast == $past(last_slot))
    else $error("tlast does not match final slot");

endmodule

### src/mmsq_decode.sv
// Square decoder: distinct labels, case indexes and segment compaction.
// Depends on mmsq_pkg.
module mmsq_decode
  import mmsq_pkg::*;
#(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [CORNERS-1:0][LABEL_BITS-1:0] labels,
  input  logic [MASK_W-1:0]                  present,
  input  logic signed [COORD_BITS-1:0]       origin_x,
  input  logic signed [COORD_BITS-1:0]       origin_y,
  input  logic [PLANE_W-1:0]                 plane,
  input  logic [LABEL_BITS-1:0]              default_label,
  input  logic [HALF_W-1:0]                  half_cell_x,
  input  logic [HALF_W-1:0]                  half_cell_y,
  output square_t                            sq
);

  logic [CORNERS-1:0][LABEL_BITS-1:0] bits;
  logic [CORNERS-1:0]                 first;
  logic [CORNERS-1:0]                 emit;
  logic [CORNERS-1:0][3:0]            cidx;
  logic [CORNERS-1:0][1:0]            cnt;
  logic [CORNERS:0][3:0]              off;
  logic [CNT_W-1:0]                   ndist;

  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      bits[i]  = present[i] ? labels[i] : default_label;
      first[i] = present[i];
      for (int k = 0; k < i; k++) begin
        if (present[k] && labels[k] == labels[i]) begin
          first[i] = 1'b0;
        end
      end
    end
    ndist = CNT_W'(first[0]) + CNT_W'(first[1]) + CNT_W'(first[2]) + CNT_W'(first[3]);
    off[0] = 4'd0;
    for (int j = 0; j < CORNERS; j++) begin
      emit[j] = first[j] && labels[j] != default_label && ndist >= CNT_W'(2);
      for (int i = 0; i < CORNERS; i++) begin
        cidx[j][i] = bits[i] == labels[j];
      end
      cnt[j]   = emit[j] ? seg_count(cidx[j]) : 2'd0;
      off[j+1] = off[j] + 4'(cnt[j]);
    end
  end

  always_comb begin
    sq = '0;
    sq.n = (off[CORNERS] > 4'(MAX_SEGS)) ? CNT_W'(MAX_SEGS) : CNT_W'(off[CORNERS]);
    for (int k = 0; k < MAX_SEGS; k++) begin
      for (int j = 0; j < CORNERS; j++) begin
        for (int s = 0; s < 2; s++) begin
          if (2'(s) < cnt[j] && off[j] + 4'(s) == 4'(k)) begin
            sq.label[k] = LBL_W'(labels[j]);
            sq.idx[k]   = cidx[j];
            sq.sel[k]   = 1'(s);
          end
        end
      end
    end
    sq.plane = plane;
    sq.cx    = POS_W'(origin_x) + POS_W'(half_cell_x);
    sq.cy    = POS_W'(origin_y) + POS_W'(half_cell_y);
  end

endmodule
